// ----- rtl/kmrb_pkg.sv -----
// Shared constants, types and result struct for the key matrix report builder.
package kmrb_pkg;

  localparam int COLUMNS      = 5;
  localparam int ROWS         = 5;
  localparam int REPORT_SLOTS = 6;

  localparam int MATRIX_BITS  = 25;
  localparam int SLOT_FIELDS  = 6;
  localparam int KEYMAP_WORDS = 4;
  localparam int WORD_BYTES   = 8;
  localparam int CODE_W       = 8;
  localparam int WORD_W       = CODE_W * WORD_BYTES;
  localparam int COUNT_W      = 3;
  localparam int CFG_INDEX_W  = 8;

  localparam int SCAN_CELLS   = COLUMNS * ROWS;
  localparam int POSITIONS    = (SCAN_CELLS < MATRIX_BITS) ? SCAN_CELLS : MATRIX_BITS;
  localparam int RANK_W       = $clog2(POSITIONS + 1);

  localparam logic [CODE_W-1:0] UNUSED_CODE  = 8'h00;
  localparam logic [CODE_W-1:0] SPECIAL_CODE = 8'hFF;

  typedef logic [CODE_W-1:0]      code_t;
  typedef logic [WORD_W-1:0]      keymap_word_t;
  typedef logic [MATRIX_BITS-1:0] matrix_t;
  typedef logic [COUNT_W-1:0]     count_t;

  typedef struct packed {
    code_t [SLOT_FIELDS-1:0] slot;
    count_t                  key_count;
    logic                    led_request;
    logic                    overflow;
  } report_t;

endpackage

// ----- rtl/key_matrix_report_builder.sv -----
// Top level: input register, report compaction and result register.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_pressed_matrix[24:0]
//   out_    | output    | out_valid/out_stall| out_key_slot0..5, out_key_count,
//           |           |                    | out_led_request, out_overflow
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data (keymap words)
//
// One item per cycle sustained while out_stall is low; the input register takes
// the accepted item, then the result register takes its report and raises out_valid.
// Synchronous active-low reset clears both valid flags and the keymap.
// A stalled result holds; one more item is taken into the input register
// behind it, and in_stall rises only when both registers are full.
module key_matrix_report_builder
  import kmrb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [MATRIX_BITS-1:0] in_pressed_matrix,

  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CODE_W-1:0]      out_key_slot0,
  output logic [CODE_W-1:0]      out_key_slot1,
  output logic [CODE_W-1:0]      out_key_slot2,
  output logic [CODE_W-1:0]      out_key_slot3,
  output logic [CODE_W-1:0]      out_key_slot4,
  output logic [CODE_W-1:0]      out_key_slot5,
  output logic [COUNT_W-1:0]     out_key_count,
  output logic                   out_led_request,
  output logic                   out_overflow,

  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data
);

  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  matrix_t               s1_matrix_r;
  matrix_t               s1_matrix_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  report_t               report_r;
  report_t               report_nxt;
  report_t               report_comb;
  code_t [POSITIONS-1:0] pos_code;
  logic                  out_load;
  logic                  in_acc;

  assign cfg_ready = 1'b1;

  kmrb_keymap u_keymap (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pos_code  (pos_code)
  );

  kmrb_compact u_compact (
    .matrix   (s1_matrix_r),
    .pos_code (pos_code),
    .report   (report_comb)
  );

  assign out_load = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_load;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_matrix_nxt = in_acc ? in_pressed_matrix : s1_matrix_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    out_valid_nxt = out_load ? s1_valid_r : out_valid_r;
    report_nxt    = (out_load && s1_valid_r) ? report_comb : report_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_matrix_r <= s1_matrix_nxt;
    report_r    <= report_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_key_slot0   = report_r.slot[0];
  assign out_key_slot1   = report_r.slot[1];
  assign out_key_slot2   = report_r.slot[2];
  assign out_key_slot3   = report_r.slot[3];
  assign out_key_slot4   = report_r.slot[4];
  assign out_key_slot5   = report_r.slot[5];
  assign out_key_count   = report_r.key_count;
  assign out_led_request = report_r.led_request;
  assign out_overflow    = report_r.overflow;

endmodule

// ----- rtl/kmrb_keymap.sv -----
// Keymap configuration registers and per-position key code fan-out.
module kmrb_keymap
  import kmrb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  keymap_word_t           cfg_data,
  output code_t [POSITIONS-1:0]  pos_code
);

  keymap_word_t [KEYMAP_WORDS-1:0] keymap_r;
  keymap_word_t [KEYMAP_WORDS-1:0] keymap_nxt;

  always_comb begin
    for (int w = 0; w < KEYMAP_WORDS; w++) begin
      if (cfg_we && (cfg_index == CFG_INDEX_W'(w))) begin
        keymap_nxt[w] = cfg_data;
      end else begin
        keymap_nxt[w] = keymap_r[w];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keymap_r <= '0;
    end else begin
      keymap_r <= keymap_nxt;
    end
  end

  for (genvar p = 0; p < POSITIONS; p++) begin : g_pos
    localparam int WordSel = (p / WORD_BYTES) % KEYMAP_WORDS;
    localparam int ByteSel = p % WORD_BYTES;
    assign pos_code[p] = keymap_r[WordSel][ByteSel*CODE_W +: CODE_W];
  end

endmodule

// ----- rtl/kmrb_compact.sv -----
// Classifies pressed positions and packs ordinary key codes into report slots.
module kmrb_compact
  import kmrb_pkg::*;
(
  input  matrix_t               matrix,
  input  code_t [POSITIONS-1:0] pos_code,
  output report_t               report
);

  logic [POSITIONS-1:0]         ordinary;
  logic [POSITIONS-1:0]         special;
  logic [POSITIONS-1:0][RANK_W-1:0] rank;
  logic [RANK_W-1:0]            total;

  always_comb begin
    for (int p = 0; p < POSITIONS; p++) begin
      ordinary[p] = matrix[p] && (pos_code[p] != UNUSED_CODE) &&
                    (pos_code[p] != SPECIAL_CODE);
      special[p]  = matrix[p] && (pos_code[p] == SPECIAL_CODE);
    end
  end

  // rank each position by the ordinary keys scanned ahead of it
  always_comb begin
    for (int p = 0; p < POSITIONS; p++) begin
      rank[p] = RANK_W'($countones(ordinary & ((POSITIONS'(1) << p) - POSITIONS'(1))));
    end
    total = RANK_W'($countones(ordinary));
  end

  always_comb begin
    report = '0;
    for (int j = 0; j < SLOT_FIELDS; j++) begin
      if (j < REPORT_SLOTS) begin
        for (int p = 0; p < POSITIONS; p++) begin
          if (ordinary[p] && (rank[p] == RANK_W'(j))) begin
            report.slot[j] = report.slot[j] | pos_code[p];
          end
        end
      end
    end
    if (total > RANK_W'(REPORT_SLOTS)) begin
      report.key_count = COUNT_W'(REPORT_SLOTS);
      report.overflow  = 1'b1;
    end else begin
      report.key_count = COUNT_W'(total);
      report.overflow  = 1'b0;
    end
    report.led_request = |special;
  end

endmodule
